@@ hdl/ffba_pkg.sv @@
// Shared types and constants for the first-fit block allocator.
// Used by ffba_ctrl, ffba_datapath and first_fit_block_allocator; no dependencies.
package ffba_pkg;

    localparam int HEAP_BYTES_DEF = 2048;
    localparam int SLOTS_DEF      = 64;

    localparam int SIZE_W   = 12;
    localparam int ADDR_W   = 11;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_GAP       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RESERVED = 2'd3;

    typedef struct packed {
        logic load;
        logic check;
        logic walk;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic full;
        logic fit;
        logic walk_end;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hdl/ffba_ctrl.sv @@
// Controller state machine of the first-fit block allocator.
// Depends on ffba_pkg for the command and status structs.
module ffba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ffba_pkg::t_dp_stat i_stat,
    output ffba_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_WALK  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.is_free || i_stat.full) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.fit || i_stat.walk_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/ffba_datapath.sv @@
// Datapath of the first-fit block allocator: slot table, candidate walk, result register.
// Depends on ffba_pkg; driven by ffba_ctrl through t_dp_cmd.
module ffba_datapath #(
    parameter int HEAP_BYTES = ffba_pkg::HEAP_BYTES_DEF,
    parameter int SLOTS      = ffba_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ffba_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [ffba_pkg::M_DATA_W-1:0]  m_tdata,
    input  ffba_pkg::t_dp_cmd              i_cmd,
    output ffba_pkg::t_dp_stat             o_stat
);

    localparam int HEAP_W = $clog2(HEAP_BYTES + 1);
    localparam int OFF_W  = (HEAP_W > ffba_pkg::SIZE_W) ? HEAP_W : ffba_pkg::SIZE_W;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = $clog2(SLOTS + 2);
    localparam logic [OFF_W:0]   HEAP_LIM = (OFF_W + 1)'(HEAP_BYTES);
    localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(SLOTS + 1);

    logic                             r_cmd;
    logic [ffba_pkg::SIZE_W-1:0]      r_size;
    logic [ffba_pkg::ADDR_W-1:0]      r_addr;
    logic [SLOTS-1:0]                 r_used;
    logic [OFF_W-1:0]                 r_start [SLOTS];
    logic [OFF_W-1:0]                 r_end   [SLOTS];
    logic [SLOT_W-1:0]                r_free_slot;
    logic [IDX_W-1:0]                 r_idx;
    logic [OFF_W-1:0]                 r_cand;
    logic                             r_cand_vld;
    logic [ffba_pkg::STATUS_W-1:0]    r_status;
    logic [ffba_pkg::ADDR_W-1:0]      r_grant;
    logic                             r_out_vld;
    logic [ffba_pkg::STATUS_W-1:0]    r_out_status;
    logic [ffba_pkg::ADDR_W-1:0]      r_out_grant;

    logic [SLOTS-1:0]  w_match;
    logic [SLOTS-1:0]  w_hit;
    logic [SLOT_W-1:0] w_match_slot;
    logic [SLOT_W-1:0] w_free_slot;
    logic              w_match_any;
    logic              w_full;
    logic [OFF_W:0]    w_limit;
    logic              w_fit;
    logic              w_fetch_on;
    logic [SLOT_W-1:0] w_fetch_slot;
    logic [IDX_W-1:0]  w_idx_m1;
    logic              w_fetch_vld;
    logic              w_walk_end;

    assign w_limit = {1'b0, r_cand} + (OFF_W + 1)'(r_size);

    for (genvar k = 0; k < SLOTS; k++) begin : g_cmp
        assign w_match[k] = r_used[k] && (r_start[k] == OFF_W'(r_addr));
        assign w_hit[k]   = r_used[k] && (r_start[k] >= r_cand)
                            && ({1'b0, r_start[k]} < w_limit);
    end

    always_comb begin
        w_match_slot = '0;
        w_free_slot  = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_match_slot = SLOT_W'(k);
            end
            if (!r_used[k]) begin
                w_free_slot = SLOT_W'(k);
            end
        end
    end

    assign w_match_any  = |w_match;
    assign w_full       = &r_used;
    assign w_fit        = r_cand_vld && ({1'b0, r_cand} < HEAP_LIM)
                          && (w_limit <= HEAP_LIM) && !(|w_hit);
    assign w_fetch_on   = (r_idx != IDX_END);
    assign w_idx_m1     = r_idx - 1'b1;
    assign w_fetch_slot = w_idx_m1[SLOT_W-1:0];
    assign w_fetch_vld  = (r_idx == '0) || r_used[w_fetch_slot];
    assign w_walk_end   = !w_fetch_on && !r_cand_vld;

    assign o_stat.is_free  = (r_cmd == ffba_pkg::CMD_FREE);
    assign o_stat.full     = w_full;
    assign o_stat.fit      = w_fit;
    assign o_stat.walk_end = w_walk_end;
    assign o_stat.out_free = !r_out_vld || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_idx      <= '0;
            r_cand_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                r_idx      <= '0;
                r_cand_vld <= 1'b0;
                if (r_cmd == ffba_pkg::CMD_FREE && w_match_any) begin
                    r_used[w_match_slot] <= 1'b0;
                end
            end
            if (i_cmd.walk) begin
                if (w_fit) begin
                    r_used[r_free_slot] <= 1'b1;
                end
                if (w_fetch_on) begin
                    r_idx      <= r_idx + 1'b1;
                    r_cand_vld <= w_fetch_vld;
                end else begin
                    r_cand_vld <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= s_tuser;
            r_size <= s_tdata[ffba_pkg::SIZE_W-1:0];
            r_addr <= s_tdata[ffba_pkg::SIZE_W +: ffba_pkg::ADDR_W];
        end
        if (i_cmd.check) begin
            r_free_slot <= w_free_slot;
            r_grant     <= '0;
            if (r_cmd == ffba_pkg::CMD_FREE) begin
                r_status <= w_match_any ? ffba_pkg::ST_OK : ffba_pkg::ST_NOT_RESERVED;
            end else if (w_full) begin
                r_status <= ffba_pkg::ST_TABLE_FULL;
            end else begin
                r_status <= ffba_pkg::ST_NO_GAP;
            end
        end
        if (i_cmd.walk) begin
            r_cand <= (r_idx == '0) ? '0 : r_end[w_fetch_slot];
            if (w_fit) begin
                r_start[r_free_slot] <= r_cand;
                r_end[r_free_slot]   <= w_limit[OFF_W-1:0];
                r_status             <= ffba_pkg::ST_OK;
                r_grant              <= r_cand[ffba_pkg::ADDR_W-1:0];
            end else if (w_walk_end) begin
                r_status <= ffba_pkg::ST_NO_GAP;
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_grant  <= r_grant;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {(ffba_pkg::M_DATA_W - ffba_pkg::ADDR_W - ffba_pkg::STATUS_W)'(0),
                       r_out_grant, r_out_status};

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// First-fit block allocator over a fixed heap with a table of SLOTS reserved blocks.
// Top level; instantiates ffba_ctrl and ffba_datapath, uses ffba_pkg.
//
// One command at a time: a free returns its result straight after the check, with no walk; an
// allocate walks the heap base and then each slot end, one candidate per cycle, each checked
// against all block starts at once, and stops early when a gap is found. A full table answers
// straight after the check. The result sits in an output register, so the next command is
// taken while it waits.
module first_fit_block_allocator #(
    parameter int HEAP_BYTES = ffba_pkg::HEAP_BYTES_DEF,
    parameter int SLOTS      = ffba_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ffba_pkg::S_DATA_W-1:0] s_tdata,   // request_size, block_address, pad
    input  logic                          s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ffba_pkg::M_DATA_W-1:0] m_tdata    // status, granted_address, pad
);

    ffba_pkg::t_dp_cmd  w_cmd;
    ffba_pkg::t_dp_stat w_stat;

    ffba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    ffba_datapath #(
        .HEAP_BYTES (HEAP_BYTES),
        .SLOTS      (SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat)
    );

endmodule
